### hdl/aes_cbc_pkg.sv
// AES-256 CBC package: S-box, round helpers, register codes and controller commands.
// No dependencies.
package aes_cbc_pkg;

    localparam int unsigned RegIdxW = 3;

    typedef enum logic [RegIdxW-1:0] {
        REG_KEY0 = 3'd0,
        REG_KEY1 = 3'd1,
        REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3,
        REG_IVH  = 3'd4,
        REG_IVL  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic load;        // take input item, start round 0
        logic rekey;       // new message: load key schedule and IV
        logic step;        // run one round
        logic last_round;  // round without MixColumns
        logic finish;      // latch result into chain / output
    } t_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // state byte i sits at bits 127-8i
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r+4*c] = sbox(s[127-8*(r+4*((c+r)%4)) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!last) begin
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = t[i];
        end
        return o;
    endfunction

endpackage

### hdl/aes_cbc_ctrl.sv
// AES-256 CBC controller: sequences load, 14 rounds and result handoff.
// Depends on aes_cbc_pkg.
module aes_cbc_ctrl #(
    parameter int unsigned ROUNDS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_is_final,
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output aes_cbc_pkg::t_cmd      o_cmd,
    output logic [$clog2(ROUNDS+1)-1:0] o_round
);
    localparam int unsigned RW = $clog2(ROUNDS+1);

    typedef enum logic [0:0] {S_IDLE, S_RUN} t_state;

    t_state r_state;
    logic [RW-1:0] r_round;
    logic r_mid;
    logic r_final;
    logic r_out_valid;

    logic accept;
    logic done;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept = i_in_valid && o_in_ready;
    assign done = (r_state == S_RUN) && (r_round == RW'(ROUNDS));

    always_comb begin
        o_cmd.load = accept;
        o_cmd.rekey = accept && !r_mid;
        o_cmd.step = (r_state == S_RUN);
        o_cmd.last_round = (r_round == RW'(ROUNDS));
        o_cmd.finish = done;
    end
    assign o_round = r_round;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_mid <= 1'b0;
            r_final <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RUN;
                        r_round <= RW'(1);
                        r_mid <= 1'b1;
                        r_final <= i_is_final;
                    end
                end
                S_RUN: begin
                    if (done) begin
                        r_state <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (r_final) begin
                            r_mid <= 1'b0;
                        end
                    end else begin
                        r_round <= r_round + RW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/aes_cbc_dp.sv
// AES-256 CBC datapath: config registers, on-the-fly key schedule, round unit, chain.
// Depends on aes_cbc_pkg.
module aes_cbc_dp #(
    parameter int unsigned ROUNDS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  aes_cbc_pkg::t_cmd i_cmd,
    input  logic [$clog2(ROUNDS+1)-1:0] i_round,
    input  logic [63:0]       i_plain_high,
    input  logic [63:0]       i_plain_low,
    input  logic              i_is_final,
    output logic [63:0]       o_cipher_high,
    output logic [63:0]       o_cipher_low,
    output logic              o_final_out
);
    logic [63:0] r_key [4];
    logic [127:0] r_iv;
    logic [127:0] r_chain;
    logic [255:0] r_mkey;   // key for current message
    logic [255:0] r_ks;     // round keys r, r+1 (8 words)
    logic [7:0]  r_rcon;
    logic [127:0] r_state;
    logic [127:0] r_out;
    logic r_fin;

    logic [255:0] key_src;
    logic [127:0] blk;
    logic [255:0] n_ks;
    logic [7:0] n_rcon;
    logic [127:0] rk;
    logic [127:0] rnd;
    logic [31:0] w [8];
    logic [31:0] t;

    assign key_src = i_cmd.rekey ? {r_key[0], r_key[1], r_key[2], r_key[3]} : r_mkey;
    assign blk = {i_plain_high, i_plain_low} ^ (i_cmd.rekey ? r_iv : r_chain);

    // Rounds 1..14 use halves of a rolling 256-bit window; odd rounds take the lower
    // half, even rounds take the upper half of the next window, which is then stored.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w[i] = r_ks[255-32*i -: 32];
        end
        t = aes_cbc_pkg::sub_word({w[7][23:0], w[7][31:24]}) ^ {r_rcon, 24'h0};
        n_ks[255:224] = w[0] ^ t;
        n_ks[223:192] = w[1] ^ n_ks[255:224];
        n_ks[191:160] = w[2] ^ n_ks[223:192];
        n_ks[159:128] = w[3] ^ n_ks[191:160];
        t = aes_cbc_pkg::sub_word(n_ks[159:128]);
        n_ks[127:96]  = w[4] ^ t;
        n_ks[95:64]   = w[5] ^ n_ks[127:96];
        n_ks[63:32]   = w[6] ^ n_ks[95:64];
        n_ks[31:0]    = w[7] ^ n_ks[63:32];
        n_rcon = {r_rcon[6:0], 1'b0};
        rk = i_round[0] ? r_ks[127:0] : n_ks[255:128];
    end

    assign rnd = aes_cbc_pkg::enc_round(r_state, i_cmd.last_round) ^ rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
            r_iv <= '0;
            r_fin <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    aes_cbc_pkg::REG_KEY0: r_key[0] <= i_cfg_data;
                    aes_cbc_pkg::REG_KEY1: r_key[1] <= i_cfg_data;
                    aes_cbc_pkg::REG_KEY2: r_key[2] <= i_cfg_data;
                    aes_cbc_pkg::REG_KEY3: r_key[3] <= i_cfg_data;
                    aes_cbc_pkg::REG_IVH:  r_iv[127:64] <= i_cfg_data;
                    aes_cbc_pkg::REG_IVL:  r_iv[63:0] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_fin <= i_is_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mkey <= key_src;
            r_ks <= key_src;
            r_rcon <= 8'h01;
            r_state <= blk ^ key_src[255:128];
        end else if (i_cmd.step) begin
            r_state <= rnd;
            if (!i_round[0]) begin
                r_ks <= n_ks;
                r_rcon <= n_rcon;
            end
        end
        if (i_cmd.finish) begin
            r_chain <= rnd;
            r_out <= rnd;
        end
    end

    assign o_cipher_high = r_out[127:64];
    assign o_cipher_low = r_out[63:0];
    assign o_final_out = r_fin;
endmodule

### hdl/aes256_cbc_encrypt.sv
// AES-256 CBC encryption top level: joins controller and datapath.
// Depends on aes_cbc_pkg, aes_cbc_ctrl, aes_cbc_dp.
//
// channel | signals                                   | dir
// cfg     | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
// input   | i_in_valid/o_in_ready, plain_high/low, is_final  | in
// output  | o_out_valid/i_out_ready, cipher_high/low, final_out | out
//
// Each item is loaded, then run through 14 rounds on a single round
// unit, with the key schedule rolled forward alongside it. A new item
// is taken only when idle and no result is held, or in the cycle the
// held result is taken; a stalled output holds off the input.
// Synchronous active-low reset clears the controller state, key and IV registers, the final flag and the message flag.
// Config is always ready.
module aes256_cbc_encrypt #(
    parameter int unsigned ROUNDS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    input  logic        i_is_final,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low,
    output logic        o_final_out
);
    aes_cbc_pkg::t_cmd cmd;
    logic [$clog2(ROUNDS+1)-1:0] round;

    assign o_cfg_ready = 1'b1;

    aes_cbc_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_is_final, .i_out_ready,
        .o_in_ready, .o_out_valid, .o_cmd(cmd), .o_round(round)
    );

    aes_cbc_dp #(.ROUNDS(ROUNDS)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_cmd(cmd), .i_round(round), .i_plain_high, .i_plain_low, .i_is_final,
        .o_cipher_high, .o_cipher_low, .o_final_out
    );
endmodule
